// ===== hdl/text_cell_buffer_with_diff_flush_macros.svh =====
// ----------------------------------------------------------------------------
// Text cell buffer assertion macros
// Short forms for the concurrent checks used in the buffer modules. They
// expect a clock named clk and an active-high reset named rst in scope.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_BUFFER_WITH_DIFF_FLUSH_MACROS_SVH
`define TEXT_CELL_BUFFER_WITH_DIFF_FLUSH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcbdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Text cell buffer package
// Opcodes, register indexes, field widths and the command and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcbdf_pkg;

  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_MAX_ROWS   = 32;
  localparam int DEF_COLOR_BITS = 4;

  localparam int GLYPH_W = 21;
  localparam int SCR_W   = 9;
  localparam int CFG_W   = 8;

  localparam logic [GLYPH_W-1:0] SPACE_CODE = 21'd32;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [1:0] CFG_ORIGIN_COL    = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_ROW    = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_ACTIVE_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_FL_RD,
    ST_FL_CMP,
    ST_FL_END
  } state_t;

  typedef struct packed {
    logic accept;
    logic cnt_clr;
    logic cnt_inc;
    logic sweep_cur;
    logic sweep_shown;
    logic take_cell;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic row_ok;
    logic w_zero;
    logic col_last;
    logic differ;
    logic slot_free;
    logic has_pend;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/tcbdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text cell buffer controller
// Sequences reset fill, canvas clear and the per-column row flush, and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_cell_buffer_with_diff_flush_macros.svh"

module tcbdf_ctrl
  import tcbdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep_cur   = 1'b1;
        cmd.sweep_shown = 1'b1;
        cmd.cnt_inc     = 1'b1;
        if (sts.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (opcode)
            OP_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              state_next  = ST_CLEAR;
            end
            OP_FLUSH: begin
              cmd.cnt_clr = 1'b1;
              if (sts.row_ok && !sts.w_zero) begin
                state_next = ST_FL_RD;
              end else begin
                state_next = ST_FL_END;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.sweep_cur = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_FL_RD: begin
        state_next = ST_FL_CMP;
      end
      ST_FL_CMP: begin
        // hold while a pending cell cannot move to the output register
        if (!(sts.differ && sts.has_pend && !sts.slot_free)) begin
          cmd.take_cell = sts.differ;
          if (sts.col_last) begin
            state_next = ST_FL_END;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = ST_FL_RD;
          end
        end
      end
      ST_FL_END: begin
        if (sts.slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TCB_ASSERT_NEXT(a_stall_holds,
                   state == ST_FL_CMP && sts.differ && sts.has_pend && !sts.slot_free,
                   state == ST_FL_CMP, "flush advanced past a blocked cell")
  `TCB_ASSERT_NOW(a_busy_no_accept, state != ST_IDLE, !cmd.accept, "item taken while busy")
  `TCB_ASSERT_NOW(a_ready_idle, in_ready, state == ST_IDLE, "ready raised outside idle")

endmodule

`default_nettype wire

// ===== hdl/tcbdf_dp.sv =====
// ----------------------------------------------------------------------------
// Text cell buffer datapath
// Configuration registers, current and shown cell memories, sweep/column
// counter, pending cell and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_cell_buffer_with_diff_flush_macros.svh"

module tcbdf_dp
  import tcbdf_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int COLOR_BITS = DEF_COLOR_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [1:0]         opcode,
  input  logic signed [7:0]  cell_col,
  input  logic signed [6:0]  cell_row,
  input  logic [GLYPH_W-1:0] glyph,
  input  logic [3:0]         color_code,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SCR_W-1:0]   screen_col,
  output logic [SCR_W-1:0]   screen_row,
  output logic [GLYPH_W-1:0] out_glyph,
  output logic [3:0]         out_color,
  output logic               cell_valid,
  output logic               last_of_row
);

  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CELL_W = GLYPH_W + COLOR_BITS;
  localparam logic [CELL_W-1:0] BLANK = {SPACE_CODE, {COLOR_BITS{1'b0}}};

  logic [7:0] origin_col;
  logic [7:0] origin_row;
  logic [6:0] active_width;
  logic [5:0] active_height;

  logic [CELL_W-1:0] cur_mem [CELLS];
  logic [CELL_W-1:0] shw_mem [CELLS];
  logic [CELL_W-1:0] rd_cur;
  logic [CELL_W-1:0] rd_shw;

  logic [ADDR_W-1:0] cnt;
  logic [5:0]        row_reg;
  logic              row_hit;

  logic               pend_valid;
  logic [SCR_W-1:0]   pend_col;
  logic [CELL_W-1:0]  pend_cell;

  logic [6:0]            eff_w;
  logic [SCR_W-1:0]      eff_h;
  logic [COLOR_BITS-1:0] color_s;
  logic                  col_ok;
  logic                  row_ok;
  logic                  blank_wr;
  logic                  cell_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  cur_we;
  logic [ADDR_W-1:0]     cur_waddr;
  logic [CELL_W-1:0]     cur_wdata;
  logic                  shw_we;
  logic [ADDR_W-1:0]     shw_waddr;
  logic [CELL_W-1:0]     shw_wdata;
  logic [SCR_W-1:0]      flush_row;
  logic                  out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_col    <= 8'd0;
      origin_row    <= 8'd0;
      active_width  <= 7'd64;
      active_height <= 6'd32;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ORIGIN_COL:    origin_col    <= cfg_data;
        CFG_ORIGIN_ROW:    origin_row    <= cfg_data;
        CFG_ACTIVE_WIDTH:  active_width  <= cfg_data[6:0];
        CFG_ACTIVE_HEIGHT: active_height <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Input decode for writes and flush row checks
  always_comb begin
    eff_w    = (32'(active_width) < MAX_COLS) ? active_width : 7'(MAX_COLS);
    eff_h    = (32'(active_height) < MAX_ROWS) ? SCR_W'(active_height) : SCR_W'(MAX_ROWS);
    color_s  = COLOR_BITS'(color_code);
    col_ok   = !cell_col[7] && (32'(cell_col[6:0]) < 32'(eff_w));
    row_ok   = !cell_row[6] && (32'(cell_row[5:0]) < 32'(eff_h));
    blank_wr = (glyph == SPACE_CODE) && (color_s == '0);
    cell_we  = cmd.accept && (opcode == OP_WRITE) && col_ok && row_ok && !blank_wr;
    wr_addr  = ADDR_W'(32'(cell_row[5:0]) * MAX_COLS + 32'(cell_col[6:0]));
    rd_addr  = ADDR_W'(32'(row_reg) * MAX_COLS + 32'(cnt));

    cur_we    = cell_we || cmd.sweep_cur;
    cur_waddr = cmd.sweep_cur ? cnt : wr_addr;
    cur_wdata = cmd.sweep_cur ? BLANK : {glyph, color_s};
    shw_we    = cmd.sweep_shown || cmd.take_cell;
    shw_waddr = cmd.sweep_shown ? cnt : rd_addr;
    shw_wdata = cmd.sweep_shown ? BLANK : rd_cur;

    flush_row = SCR_W'(32'(origin_row) + 32'(row_reg));
    out_load  = (cmd.take_cell && pend_valid) || cmd.finish;
  end

  always_comb begin
    sts.sweep_done = (32'(cnt) == CELLS - 1);
    sts.row_ok     = row_ok;
    sts.w_zero     = (eff_w == 7'd0);
    sts.col_last   = (32'(cnt) == 32'(eff_w) - 1);
    sts.differ     = (rd_cur != rd_shw);
    sts.slot_free  = !out_valid || out_ready;
    sts.has_pend   = pend_valid;
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    rd_cur <= cur_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (shw_we) begin
      shw_mem[shw_waddr] <= shw_wdata;
    end
    rd_shw <= shw_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && opcode == OP_FLUSH) begin
      row_reg <= cell_row[5:0];
      row_hit <= row_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.take_cell) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold one changed cell back so the last one of the row can be marked
  always_ff @(posedge clk) begin
    if (cmd.take_cell) begin
      pend_col  <= SCR_W'(32'(origin_col) + 32'(cnt));
      pend_cell <= rd_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (pend_valid) begin
        screen_col  <= pend_col;
        screen_row  <= flush_row;
        out_glyph   <= pend_cell[CELL_W-1 -: GLYPH_W];
        out_color   <= 4'(pend_cell[COLOR_BITS-1:0]);
        cell_valid  <= 1'b1;
        last_of_row <= cmd.finish;
      end else begin
        screen_col  <= SCR_W'(origin_col);
        screen_row  <= row_hit ? flush_row : '0;
        out_glyph   <= '0;
        out_color   <= '0;
        cell_valid  <= 1'b0;
        last_of_row <= 1'b1;
      end
    end
  end

  `TCB_ASSERT_NOW(a_no_overwrite, out_load, !out_valid || out_ready, "output register overwritten")
  `TCB_ASSERT_NOW(a_take_on_diff, cmd.take_cell, rd_cur != rd_shw, "unchanged cell taken")
  `TCB_ASSERT_NEXT(a_finish_drains, cmd.finish,
                   !pend_valid && out_valid && last_of_row, "flush end left a cell pending")

endmodule

`default_nettype wire

// ===== hdl/text_cell_buffer_with_diff_flush.sv =====
// ----------------------------------------------------------------------------
// Double-buffered text cell canvas with a row difference flush.
// Input channel (in_valid/in_ready): opcode with cell_col, cell_row, glyph
// and color_code. Output channel (out_valid/out_ready): one transfer per
// changed cell, or one marker when the flushed row has no change.
// Configuration: cfg_write with cfg_index and cfg_data, taken at once; the
// user writes only while the block is idle; the block does not enforce it.
// Rate: cell writes are taken back to back. A clear sweeps the current
// memory one cell per cycle. A flush is accepted, then handles each active
// column with a memory read, then a compare and shown-copy update, and
// ends in a closing state; the first result leaves with the second changed
// cell or at the row end.
// Reset: a fill pass writes blank cells into both copies; in_ready stays
// low for its length.
// Stall: one changed cell is held back to mark the row end; a second one
// waits in the output register, and the flush holds until out_ready frees
// it. A finished result does not block acceptance of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_buffer_with_diff_flush
  import tcbdf_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int COLOR_BITS = DEF_COLOR_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [7:0]  cell_col,
  input  logic signed [6:0]  cell_row,
  input  logic [GLYPH_W-1:0] glyph,
  input  logic [3:0]         color_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SCR_W-1:0]   screen_col,
  output logic [SCR_W-1:0]   screen_row,
  output logic [GLYPH_W-1:0] out_glyph,
  output logic [3:0]         out_color,
  output logic               cell_valid,
  output logic               last_of_row
);

  cmd_t cmd;
  sts_t sts;

  tcbdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcbdf_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .COLOR_BITS (COLOR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .glyph       (glyph),
    .color_code  (color_code),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .screen_col  (screen_col),
    .screen_row  (screen_row),
    .out_glyph   (out_glyph),
    .out_color   (out_color),
    .cell_valid  (cell_valid),
    .last_of_row (last_of_row)
  );

endmodule

`default_nettype wire

// ===== tb/text_cell_buffer_with_diff_flush_tb.sv =====
// ----------------------------------------------------------------------------
// Text cell buffer testbench
// Drives cell writes, canvas clears and row flushes through the input
// channel. A local model of the current and shown canvases predicts every
// flushed cell and every no-change marker, and each output transfer is
// checked against the oldest prediction. The run covers several origin and
// active-size settings, random back-pressure on both channels, and one
// stretch without any idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module text_cell_buffer_with_diff_flush_tb;
  import tcbdf_pkg::*;

  localparam int COLS  = DEF_MAX_COLS;
  localparam int ROWS  = DEF_MAX_ROWS;
  localparam int CELLS = COLS * ROWS;
  // covers a full clear sweep or the longest flush
  localparam int SETTLE_CYCLES = CELLS + 2 * COLS + 16;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [3:0] TRANSPARENT = 4'd0;
  localparam logic [GLYPH_W-1:0] MAX_GLYPH = 21'h10FFFF;

  typedef struct packed {
    logic [SCR_W-1:0]   scol;
    logic [SCR_W-1:0]   srow;
    logic [GLYPH_W-1:0] glyph;
    logic [3:0]         color;
    logic               valid;
    logic               last;
  } cell_draw_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = CFG_ORIGIN_COL;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode = OP_WRITE;
  logic signed [7:0]  cell_col = '0;
  logic signed [6:0]  cell_row = '0;
  logic [GLYPH_W-1:0] glyph = '0;
  logic [3:0]         color_code = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SCR_W-1:0]   screen_col;
  logic [SCR_W-1:0]   screen_row;
  logic [GLYPH_W-1:0] out_glyph;
  logic [3:0]         out_color;
  logic               cell_valid;
  logic               last_of_row;

  text_cell_buffer_with_diff_flush dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .glyph      (glyph),
    .color_code (color_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .screen_col (screen_col),
    .screen_row (screen_row),
    .out_glyph  (out_glyph),
    .out_color  (out_color),
    .cell_valid (cell_valid),
    .last_of_row(last_of_row)
  );

  // Canvas model
  logic [GLYPH_W-1:0] cur_glyph   [CELLS];
  logic [3:0]         cur_color   [CELLS];
  logic [GLYPH_W-1:0] shown_glyph [CELLS];
  logic [3:0]         shown_color [CELLS];
  logic [7:0] origin_col_q = 8'd0;
  logic [7:0] origin_row_q = 8'd0;
  logic [6:0] width_q = 7'd64;
  logic [5:0] height_q = 6'd32;

  cell_draw_t pending_draws[$];
  cell_draw_t got_draw;
  int failures = 0;
  bit calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 22);
  end

  function automatic int canvas_cols();
    return (width_q < COLS) ? int'(width_q) : COLS;
  endfunction

  function automatic int canvas_rows();
    return (height_q < ROWS) ? int'(height_q) : ROWS;
  endfunction

  function automatic cell_draw_t make_draw(int scol, int srow, logic [GLYPH_W-1:0] g,
                                           logic [3:0] c, logic v, logic l);
    cell_draw_t d;
    d.scol  = SCR_W'(scol);
    d.srow  = SCR_W'(srow);
    d.glyph = g;
    d.color = c;
    d.valid = v;
    d.last  = l;
    return d;
  endfunction

  function automatic void blank_canvas(bit both);
    for (int i = 0; i < CELLS; i++) begin
      cur_glyph[i] = SPACE_CODE;
      cur_color[i] = TRANSPARENT;
      if (both) begin
        shown_glyph[i] = SPACE_CODE;
        shown_color[i] = TRANSPARENT;
      end
    end
  endfunction

  function automatic void update_canvas(logic [1:0] op, logic signed [7:0] col8,
                                        logic signed [6:0] row7, logic [GLYPH_W-1:0] g,
                                        logic [3:0] c);
    int col, row, w, h, idx;
    bit held;
    cell_draw_t pend;
    col = col8;
    row = row7;
    w = canvas_cols();
    h = canvas_rows();
    held = 1'b0;
    pend = '0;
    case (op)
      OP_WRITE: begin
        if (!(g == SPACE_CODE && c == TRANSPARENT) &&
            col >= 0 && col < w && row >= 0 && row < h) begin
          idx = row * COLS + col;
          cur_glyph[idx] = g;
          cur_color[idx] = c;
        end
      end
      OP_CLEAR: blank_canvas(1'b0);
      OP_FLUSH: begin
        if (row < 0 || row >= h) begin
          pending_draws.push_back(make_draw(origin_col_q, 0, '0, '0, 1'b0, 1'b1));
        end else begin
          for (int j = 0; j < w; j++) begin
            idx = row * COLS + j;
            if (cur_glyph[idx] != shown_glyph[idx] || cur_color[idx] != shown_color[idx]) begin
              shown_glyph[idx] = cur_glyph[idx];
              shown_color[idx] = cur_color[idx];
              // hold one cell back so the last one can be marked
              if (held) pending_draws.push_back(pend);
              pend = make_draw(origin_col_q + j, origin_row_q + row,
                               cur_glyph[idx], cur_color[idx], 1'b1, 1'b0);
              held = 1'b1;
            end
          end
          if (held) begin
            pend.last = 1'b1;
            pending_draws.push_back(pend);
          end else begin
            pending_draws.push_back(make_draw(origin_col_q, origin_row_q + row,
                                              '0, '0, 1'b0, 1'b1));
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [GLYPH_W-1:0] want,
                             input logic [GLYPH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected transfer: screen_col %0d screen_row %0d", screen_col, screen_row);
        failures++;
      end else begin
        got_draw = pending_draws.pop_front();
        check_field("screen_col", got_draw.scol, screen_col);
        check_field("screen_row", got_draw.srow, screen_row);
        check_field("out_glyph", got_draw.glyph, out_glyph);
        check_field("out_color", got_draw.color, out_color);
        check_field("cell_valid", got_draw.valid, cell_valid);
        check_field("last_of_row", got_draw.last, last_of_row);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with in_valid still high.
  task automatic send_op(input logic [1:0] op, input int col, input int row,
                         input logic [GLYPH_W-1:0] g, input logic [3:0] c);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    cell_col   <= 8'(col);
    cell_row   <= 7'(row);
    glyph      <= g;
    color_code <= c;
    do @(posedge clk); while (!in_ready);
    update_canvas(op, 8'(col), 7'(row), g, c);
    @(negedge clk);
  endtask

  // Drop valid, drain all results, then let any clear sweep finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_ORIGIN_COL:    origin_col_q = val;
      CFG_ORIGIN_ROW:    origin_row_q = val;
      CFG_ACTIVE_WIDTH:  width_q = val[6:0];
      CFG_ACTIVE_HEIGHT: height_q = val[5:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] ocol, input logic [7:0] orow,
                           input logic [7:0] w, input logic [7:0] h);
    settle();
    set_reg(CFG_ORIGIN_COL, ocol);
    set_reg(CFG_ORIGIN_ROW, orow);
    set_reg(CFG_ACTIVE_WIDTH, w);
    set_reg(CFG_ACTIVE_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [GLYPH_W-1:0] pick_glyph();
    case ($urandom_range(4))
      0: return SPACE_CODE;
      1: return GLYPH_W'($urandom_range(33, 126));
      default: return GLYPH_W'($urandom_range(0, int'(MAX_GLYPH)));
    endcase
  endfunction

  function automatic logic [3:0] pick_color();
    return ($urandom_range(3) == 0) ? TRANSPARENT : 4'($urandom_range(15));
  endfunction

  function automatic int any_col();
    return $urandom_range(255) - 128;
  endfunction

  function automatic int any_row();
    return $urandom_range(127) - 64;
  endfunction

  // Mostly write bursts into a few rows followed by flushes of those rows;
  // the rest is clears, noise and unused opcodes.
  task automatic run_canvas_traffic(input int n_items);
    int sent, kind, nrows, nwrites, row, col;
    int rows_hit[3];
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75 && canvas_cols() > 0 && canvas_rows() > 0) begin
        nrows = $urandom_range(1, 3);
        for (int i = 0; i < nrows; i++) rows_hit[i] = $urandom_range(0, canvas_rows() - 1);
        nwrites = $urandom_range(1, 10);
        for (int i = 0; i < nwrites; i++) begin
          row = rows_hit[$urandom_range(0, nrows - 1)];
          col = ($urandom_range(9) == 0) ? any_col() : $urandom_range(0, canvas_cols() - 1);
          send_op(OP_WRITE, col, row, pick_glyph(), pick_color());
          sent++;
        end
        for (int i = 0; i < nrows; i++) begin
          send_op(OP_FLUSH, any_col(), rows_hit[i], pick_glyph(), pick_color());
          sent++;
        end
      end else if (kind < 78) begin
        send_op(OP_CLEAR, any_col(), any_row(), pick_glyph(), pick_color());
        sent++;
      end else if (kind < 81) begin
        send_op(OP_UNUSED, any_col(), any_row(), pick_glyph(), pick_color());
      end else begin
        send_op(2'($urandom_range(0, 2)), any_col(), any_row(), pick_glyph(), pick_color());
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_op(OP_FLUSH, 0, 0, '0, '0);                   // untouched row: marker
    send_op(OP_WRITE, 0, 0, SPACE_CODE, TRANSPARENT);  // transparent space: drop
    send_op(OP_WRITE, 0, 0, MAX_GLYPH, 4'hF);
    send_op(OP_WRITE, COLS - 1, 0, '0, 4'd1);
    send_op(OP_WRITE, 1, 0, SPACE_CODE, 4'd5);
    send_op(OP_WRITE, 2, 0, 21'd65, TRANSPARENT);
    send_op(OP_WRITE, -128, 0, 21'd66, 4'd2);
    send_op(OP_WRITE, 127, 0, 21'd66, 4'd2);
    send_op(OP_WRITE, COLS, 0, 21'd66, 4'd2);
    send_op(OP_WRITE, 5, -64, 21'd67, 4'd3);
    send_op(OP_WRITE, 5, 63, 21'd67, 4'd3);
    send_op(OP_WRITE, 5, ROWS, 21'd67, 4'd3);
    send_op(OP_UNUSED, 7, 3, 21'd99, 4'd9);
    send_op(OP_FLUSH, -1, 0, MAX_GLYPH, 4'hF);
    send_op(OP_FLUSH, 0, 0, '0, '0);                   // already shown: marker
    send_op(OP_FLUSH, 0, -64, '0, '0);
    send_op(OP_FLUSH, 0, 63, '0, '0);
    send_op(OP_FLUSH, 0, ROWS, '0, '0);
    send_op(OP_WRITE, 10, ROWS - 1, 21'h1FFFF, 4'd8);
    send_op(OP_FLUSH, 0, ROWS - 1, '0, '0);
    send_op(OP_WRITE, 0, ROWS - 1, 21'd120, 4'd3);
    send_op(OP_CLEAR, 55, -7, 21'd5, 4'd6);
    send_op(OP_FLUSH, 0, ROWS - 1, '0, '0);
    send_op(OP_FLUSH, 0, 0, '0, '0);
  endtask

  task automatic test_register_extremes();
    configure(8'd255, 8'd255, 8'd64, 8'd32);
    run_canvas_traffic(30);
    configure(8'd0, 8'd0, 8'd1, 8'd1);
    run_canvas_traffic(25);
    configure(8'd17, 8'd200, 8'd127, 8'd63);  // larger than the canvas
    run_canvas_traffic(30);
    configure(8'd3, 8'd9, 8'd0, 8'd5);        // zero width
    run_canvas_traffic(20);
    configure(8'd8, 8'd4, 8'd40, 8'd0);       // zero height
    run_canvas_traffic(20);
  endtask

  task automatic test_random_settings();
    repeat (2) begin
      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_canvas_traffic(30);
    end
  endtask

  task automatic test_steady_stream();
    configure(8'($urandom), 8'($urandom), 8'($urandom_range(1, COLS)),
              8'($urandom_range(1, ROWS)));
    calm = 1'b1;
    run_canvas_traffic(60);
    settle();
    calm = 1'b0;
  endtask

  task automatic test_default_canvas();
    configure(8'd0, 8'd0, 8'd64, 8'd32);
    run_canvas_traffic(100);
  endtask

  initial begin
    blank_canvas(1'b1);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // wait out the blank fill after reset
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    test_directed();
    test_register_extremes();
    test_random_settings();
    test_steady_stream();
    test_default_canvas();

    settle();
    if (pending_draws.size() != 0) begin
      $error("%0d expected transfers never arrived", pending_draws.size());
      failures++;
    end
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
